/* rtl/pointer_ballistics_mapper_assert.svh */
// ----------------------------------------------------------------------------
// pointer ballistics mapper assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef POINTER_BALLISTICS_MAPPER_ASSERT_SVH
`define POINTER_BALLISTICS_MAPPER_ASSERT_SVH

// same-cycle implication
`define PBM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pbm assertion failed");

// next-cycle implication
`define PBM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pbm assertion failed");

`endif

/* rtl/pbm_pkg.sv */
// ----------------------------------------------------------------------------
// pbm_pkg
// constants, command and status types and log2 / exp2 node tables
// ----------------------------------------------------------------------------
package pbm_pkg;

    localparam int EDGE_PAD          = 20;
    localparam int LOG_TABLE_ENTRIES = 64;
    localparam int LOG_IDX_W         = $clog2(LOG_TABLE_ENTRIES + 1);
    localparam int POS_W             = 16 + LOG_IDX_W;

    localparam logic signed [23:0] LOG2_005 = -24'sd283242;
    localparam logic [17:0] MULT_MIN = 18'd13107;
    localparam logic [17:0] MULT_MAX = 18'd229376;
    localparam logic [17:0] MULT_ONE = 18'd65536;
    localparam int SMALL_SUM_MAX = 655;

    localparam int DIV_STEPS  = 21;
    localparam int SQRT_STEPS = 22;
    localparam int CNT_W      = 5;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 4'd0,
        REG_SCREEN_HEIGHT = 4'd1,
        REG_GAIN          = 4'd2,
        REG_ACCEL         = 4'd3,
        REG_WINDOW_LEFT   = 4'd4,
        REG_WINDOW_RIGHT  = 4'd5,
        REG_WINDOW_TOP    = 4'd6,
        REG_WINDOW_BOTTOM = 4'd7
    } t_cfg_reg;

    typedef enum logic [1:0] {
        OUT_ZERO  = 2'd0,
        OUT_TRUNC = 2'd1,
        OUT_ROUND = 2'd2
    } t_out_kind;

    typedef struct packed {
        logic      load;
        logic      axis;
        logic      map_setup;
        logic      div_step;
        logic      map_store;
        logic      first_store;
        logic      sq_x;
        logic      sq_y;
        logic      sqrt_init;
        logic      sqrt_step;
        logic      norm_step;
        logic      log_step;
        logic      pow_step;
        logic      exp_step;
        logic      scale_step;
        logic      shift_step;
        logic      unity;
        logic      mv_mul;
        logic      mv_fin;
        logic      out_load;
        t_out_kind out_kind;
    } t_pbm_cmd;

    typedef struct packed {
        logic short_move;
        logic norm_done;
    } t_pbm_stat;

    typedef logic [LOG_TABLE_ENTRIES:0][17:0] t_node_tab;

    // log2 of a Q1.16 mantissa by repeated squaring
    function automatic logic [16:0] f_log2_sq(input logic [17:0] m);
        logic [35:0] x;
        logic [16:0] y;
        x = 36'(m);
        y = '0;
        for (int k = 1; k <= 16; k++) begin
            x = (x * x) >> 16;
            if (x >= 36'd131072) begin
                x = x >> 1;
                y[16-k] = 1'b1;
            end
        end
        return y;
    endfunction

    function automatic t_node_tab f_build_log();
        t_node_tab tab;
        for (int i = 0; i <= LOG_TABLE_ENTRIES; i++) begin
            if (i == LOG_TABLE_ENTRIES) begin
                tab[i] = 18'd65536;
            end else begin
                tab[i] = 18'(f_log2_sq(18'(65536 + (i * 65536) / LOG_TABLE_ENTRIES)));
            end
        end
        return tab;
    endfunction

    function automatic t_node_tab f_build_exp();
        t_node_tab tab;
        int lo;
        int hi;
        int mid;
        int q;
        for (int i = 0; i <= LOG_TABLE_ENTRIES; i++) begin
            if (i == LOG_TABLE_ENTRIES) begin
                tab[i] = 18'd131072;
            end else begin
                q  = (i * 65536) / LOG_TABLE_ENTRIES;
                lo = 65536;
                hi = 131072;
                for (int it = 0; it < 18; it++) begin
                    if (lo < hi) begin
                        mid = (lo + hi) >> 1;
                        if (int'(f_log2_sq(18'(mid))) >= q) begin
                            hi = mid;
                        end else begin
                            lo = mid + 1;
                        end
                    end
                end
                tab[i] = 18'(lo);
            end
        end
        return tab;
    endfunction

    localparam t_node_tab LOG_NODES = f_build_log();
    localparam t_node_tab EXP_NODES = f_build_exp();

endpackage

/* rtl/pbm_datapath.sv */
// ----------------------------------------------------------------------------
// pbm_datapath
// config registers, window mapping divider, distance, sqrt, log/exp gain
// and cursor move with edge snapping
// ----------------------------------------------------------------------------
module pbm_datapath import pbm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [15:0]           i_cam_x,
    input  logic [15:0]           i_cam_y,
    input  t_pbm_cmd              i_cmd,
    output t_pbm_stat             o_stat,
    output logic [12:0]           o_pixel_x,
    output logic [12:0]           o_pixel_y
);

    logic [12:0] r_width, r_height;
    logic [11:0] r_gain, r_accel;
    logic [15:0] r_win_l, r_win_r, r_win_t, r_win_b;

    logic [15:0] r_cam_x, r_cam_y;
    logic [15:0] r_div_rem, r_div_den;
    logic [20:0] r_div_q;
    logic        r_map_special;
    logic [20:0] r_map_spval;
    logic [20:0] r_tx, r_ty, r_prev_x, r_prev_y;
    logic signed [21:0] r_dx, r_dy;
    logic [43:0] r_sum, r_sqv;
    logic [21:0] r_root, r_dn;
    logic [23:0] r_srem;
    logic [4:0]  r_p;
    logic [16:0] r_logv;
    logic signed [28:0] r_pw;
    logic [17:0] r_e, r_mult;
    logic [29:0] r_prod;
    logic signed [24:0] r_mv;
    logic [12:0] r_pix_x, r_pix_y;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 13'd1920;
            r_height <= 13'd1080;
            r_gain   <= 12'd384;
            r_accel  <= 12'd512;
            r_win_l  <= 16'd13107;
            r_win_r  <= 16'd52429;
            r_win_t  <= 16'd13107;
            r_win_b  <= 16'd45875;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SCREEN_WIDTH:  r_width  <= i_cfg_data[12:0];
                REG_SCREEN_HEIGHT: r_height <= i_cfg_data[12:0];
                REG_GAIN:          r_gain   <= i_cfg_data[11:0];
                REG_ACCEL:         r_accel  <= i_cfg_data[11:0];
                REG_WINDOW_LEFT:   r_win_l  <= i_cfg_data;
                REG_WINDOW_RIGHT:  r_win_r  <= i_cfg_data;
                REG_WINDOW_TOP:    r_win_t  <= i_cfg_data;
                REG_WINDOW_BOTTOM: r_win_b  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // window mapping
    logic [15:0]        m_cam, m_lo, m_hi;
    logic [12:0]        m_size;
    logic signed [16:0] m_num, m_den, m_num_a, m_den_a;
    logic               m_zero, m_full;
    logic [28:0]        m_prod;
    logic [16:0]        d_rem2, d_sub;
    logic               d_ge;
    logic [20:0]        m_t;

    assign m_cam   = i_cmd.axis ? r_cam_y : r_cam_x;
    assign m_lo    = i_cmd.axis ? r_win_t : r_win_l;
    assign m_hi    = i_cmd.axis ? r_win_b : r_win_r;
    assign m_size  = i_cmd.axis ? r_height : r_width;
    assign m_num   = signed'({1'b0, m_cam}) - signed'({1'b0, m_lo});
    assign m_den   = signed'({1'b0, m_hi}) - signed'({1'b0, m_lo});
    assign m_num_a = m_den[16] ? -m_num : m_num;
    assign m_den_a = m_den[16] ? -m_den : m_den;
    assign m_zero  = (m_den_a == 17'sd0) || (m_num_a <= 17'sd0);
    assign m_full  = m_num_a >= m_den_a;
    assign m_prod  = 29'(m_num_a[15:0]) * 29'(m_size);
    assign d_rem2  = {r_div_rem, r_div_q[20]};
    assign d_ge    = d_rem2 >= {1'b0, r_div_den};
    assign d_sub   = d_rem2 - {1'b0, r_div_den};
    assign m_t     = r_map_special ? r_map_spval : r_div_q;

    // distance
    logic signed [21:0] s_dx, s_dy;
    logic signed [43:0] s_sqx, s_sqy;

    assign s_dx  = signed'({1'b0, r_tx}) - signed'({1'b0, r_prev_x});
    assign s_dy  = signed'({1'b0, r_ty}) - signed'({1'b0, r_prev_y});
    assign s_sqx = 44'(s_dx) * 44'(s_dx);
    assign s_sqy = 44'(r_dy) * 44'(r_dy);

    // square root step
    logic [25:0] q_rem2, q_trial, q_diff;
    logic        q_ge;

    assign q_rem2  = {r_srem, r_sqv[43:42]};
    assign q_trial = {2'b00, r_root, 2'b01};
    assign q_ge    = q_rem2 >= q_trial;
    assign q_diff  = q_rem2 - q_trial;

    // shared table interpolation
    logic [15:0]          t_frac;
    logic [POS_W-1:0]     t_pos;
    logic [LOG_IDX_W-1:0] t_i, t_i1;
    logic [15:0]          t_r;
    logic [17:0]          t_a, t_b, t_diff, t_res;
    logic [33:0]          t_int;

    assign t_frac = i_cmd.exp_step ? r_pw[15:0] : r_dn[20:5];
    assign t_pos  = POS_W'(t_frac) * POS_W'(LOG_TABLE_ENTRIES);
    assign t_i    = t_pos[POS_W-1:16];
    assign t_r    = t_pos[15:0];
    assign t_i1   = t_i + LOG_IDX_W'(1);
    assign t_a    = i_cmd.exp_step ? EXP_NODES[t_i]  : LOG_NODES[t_i];
    assign t_b    = i_cmd.exp_step ? EXP_NODES[t_i1] : LOG_NODES[t_i1];
    assign t_diff = t_b - t_a;
    assign t_int  = 34'(t_diff) * 34'(t_r);
    assign t_res  = t_a + t_int[33:16];

    // exponent
    logic signed [7:0]  p_m8;
    logic signed [23:0] p_l;
    logic signed [12:0] p_acc;
    logic signed [36:0] p_prod;

    assign p_m8   = signed'({3'b000, r_p}) - 8'sd8;
    assign p_l    = signed'({p_m8, 16'h0000}) + signed'({7'b0, r_logv}) + LOG2_005;
    assign p_acc  = signed'({1'b0, r_accel}) - 13'sd256;
    assign p_prod = 37'(p_acc) * 37'(p_l);

    // gain scaling
    logic signed [12:0] h_n;
    logic [4:0]         h_shr;
    logic [1:0]         h_shl;
    logic [33:0]        h_val;
    logic [17:0]        h_mult;

    assign h_n   = r_pw[28:16];
    assign h_shr = 5'(13'sd8 - h_n);
    assign h_shl = 2'(h_n - 13'sd8);
    assign h_val = (h_n <= 13'sd8) ? (34'(r_prod) >> h_shr) : (34'(r_prod) << h_shl);

    always_comb begin
        if ((r_gain == 12'd0) || (h_n < -13'sd20)) begin
            h_mult = MULT_MIN;
        end else if (h_n >= 13'sd12) begin
            h_mult = MULT_MAX;
        end else if (h_val < 34'(MULT_MIN)) begin
            h_mult = MULT_MIN;
        end else if (h_val > 34'(MULT_MAX)) begin
            h_mult = MULT_MAX;
        end else begin
            h_mult = h_val[17:0];
        end
    end

    // move and edge snap
    logic signed [21:0] v_d;
    logic signed [40:0] v_prod, v_rnd;
    logic [20:0]        v_prev, v_new;
    logic [12:0]        v_size;
    logic signed [25:0] v_fin, v_f2, v_lim, v_pad;

    assign v_d    = i_cmd.axis ? r_dy : r_dx;
    assign v_prod = 41'(v_d) * 41'(signed'({1'b0, r_mult}));
    assign v_rnd  = v_prod + 41'sd32768;
    assign v_prev = i_cmd.axis ? r_prev_y : r_prev_x;
    assign v_size = i_cmd.axis ? r_height : r_width;
    assign v_fin  = signed'({5'b0, v_prev}) + 26'(r_mv);
    assign v_pad  = 26'(EDGE_PAD * 256);
    assign v_lim  = signed'({5'b0, v_size, 8'h00}) - v_pad;
    assign v_f2   = (v_fin < v_pad) ? 26'sd0 : v_fin;
    assign v_new  = (v_f2 > v_lim) ? {v_size, 8'h00} : v_f2[20:0];

    // output
    logic [21:0] o_rx, o_ry;
    assign o_rx = 22'(r_prev_x) + 22'd128;
    assign o_ry = 22'(r_prev_y) + 22'd128;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cam_x <= i_cam_x;
            r_cam_y <= i_cam_y;
        end
        if (i_cmd.map_setup) begin
            r_div_rem     <= m_prod[28:13];
            r_div_q       <= {m_prod[12:0], 8'h00};
            r_div_den     <= m_den_a[15:0];
            r_map_special <= m_zero || m_full;
            r_map_spval   <= m_zero ? 21'd0 : {m_size, 8'h00};
        end
        if (i_cmd.div_step) begin
            r_div_rem <= d_ge ? d_sub[15:0] : d_rem2[15:0];
            r_div_q   <= {r_div_q[19:0], d_ge};
        end
        if (i_cmd.map_store) begin
            if (i_cmd.axis) begin
                r_ty <= m_t;
            end else begin
                r_tx <= m_t;
            end
        end
        if (i_cmd.sq_x) begin
            r_dx  <= s_dx;
            r_dy  <= s_dy;
            r_sum <= unsigned'(s_sqx);
        end
        if (i_cmd.sq_y) begin
            r_sum <= r_sum + unsigned'(s_sqy);
        end
        if (i_cmd.sqrt_init) begin
            r_sqv  <= r_sum;
            r_root <= '0;
            r_srem <= '0;
        end
        if (i_cmd.sqrt_step) begin
            r_sqv  <= r_sqv << 2;
            r_srem <= q_ge ? q_diff[23:0] : q_rem2[23:0];
            r_root <= {r_root[20:0], q_ge};
            r_dn   <= {r_root[20:0], q_ge};
            r_p    <= 5'd21;
        end
        if (i_cmd.norm_step) begin
            r_dn <= r_dn << 1;
            r_p  <= r_p - 5'd1;
        end
        if (i_cmd.log_step) begin
            r_logv <= 17'(t_res);
        end
        if (i_cmd.pow_step) begin
            r_pw <= 29'(p_prod >>> 8);
        end
        if (i_cmd.exp_step) begin
            r_e <= t_res;
        end
        if (i_cmd.scale_step) begin
            r_prod <= 30'(r_e) * 30'(r_gain);
        end
        if (i_cmd.shift_step) begin
            r_mult <= h_mult;
        end
        if (i_cmd.unity) begin
            r_mult <= MULT_ONE;
        end
        if (i_cmd.mv_mul) begin
            r_mv <= 25'(v_rnd >>> 16);
        end
        if (i_cmd.first_store) begin
            // y target is stored in this same cycle
            r_prev_x <= r_tx;
            r_prev_y <= m_t;
        end else if (i_cmd.mv_fin) begin
            if (i_cmd.axis) begin
                r_prev_y <= v_new;
            end else begin
                r_prev_x <= v_new;
            end
        end
        if (i_cmd.out_load) begin
            case (i_cmd.out_kind)
                OUT_TRUNC: begin
                    r_pix_x <= r_prev_x[20:8];
                    r_pix_y <= r_prev_y[20:8];
                end
                OUT_ROUND: begin
                    r_pix_x <= o_rx[20:8];
                    r_pix_y <= o_ry[20:8];
                end
                default: begin
                    r_pix_x <= '0;
                    r_pix_y <= '0;
                end
            endcase
        end
    end

    assign o_stat.short_move = r_sum <= 44'(SMALL_SUM_MAX);
    assign o_stat.norm_done  = r_dn[21];
    assign o_pixel_x         = r_pix_x;
    assign o_pixel_y         = r_pix_y;

endmodule

/* rtl/pbm_ctrl.sv */
// ----------------------------------------------------------------------------
// pbm_ctrl
// sequencer for one request, handshakes and the tracking flag
// ----------------------------------------------------------------------------
`include "pointer_ballistics_mapper_assert.svh"

module pbm_ctrl import pbm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_mode,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    input  t_pbm_stat i_stat,
    output t_pbm_cmd  o_cmd
);

    typedef enum logic [16:0] {
        S_IDLE      = 17'h00001,
        S_MAP_MUL   = 17'h00002,
        S_MAP_DIV   = 17'h00004,
        S_MAP_STORE = 17'h00008,
        S_SQ_X      = 17'h00010,
        S_SQ_Y      = 17'h00020,
        S_CHECK     = 17'h00040,
        S_SQRT      = 17'h00080,
        S_NORM      = 17'h00100,
        S_LOG       = 17'h00200,
        S_POW       = 17'h00400,
        S_EXP       = 17'h00800,
        S_SCALE     = 17'h01000,
        S_SHIFT     = 17'h02000,
        S_MV_MUL    = 17'h04000,
        S_MV_FIN    = 17'h08000,
        S_DONE      = 17'h10000
    } t_state;

    t_state     r_state, n_state;
    logic       r_axis, n_axis;
    logic [CNT_W-1:0] r_count, n_count;
    logic       r_have_prev, n_have_prev;
    logic       r_out_valid, n_out_valid;
    t_out_kind  r_out_kind, n_out_kind;
    logic       w_in_acc;
    t_pbm_cmd   w_cmd;

    assign w_in_acc = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_count     = r_count;
        n_have_prev = r_have_prev;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_kind  = r_out_kind;
        w_cmd          = '0;
        w_cmd.axis     = r_axis;
        w_cmd.out_kind = r_out_kind;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    w_cmd.load = 1'b1;
                    if (i_mode) begin
                        n_have_prev = 1'b0;
                        n_out_kind  = OUT_ZERO;
                        n_state     = S_DONE;
                    end else begin
                        n_axis  = 1'b0;
                        n_state = S_MAP_MUL;
                    end
                end
            end
            S_MAP_MUL: begin
                w_cmd.map_setup = 1'b1;
                n_count = '0;
                n_state = S_MAP_DIV;
            end
            S_MAP_DIV: begin
                w_cmd.div_step = 1'b1;
                n_count = r_count + CNT_W'(1);
                if (r_count == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_MAP_STORE;
                end
            end
            S_MAP_STORE: begin
                w_cmd.map_store = 1'b1;
                if (!r_axis) begin
                    n_axis  = 1'b1;
                    n_state = S_MAP_MUL;
                end else if (!r_have_prev) begin
                    w_cmd.first_store = 1'b1;
                    n_have_prev = 1'b1;
                    n_out_kind  = OUT_TRUNC;
                    n_state     = S_DONE;
                end else begin
                    n_state = S_SQ_X;
                end
            end
            S_SQ_X: begin
                w_cmd.sq_x = 1'b1;
                n_state = S_SQ_Y;
            end
            S_SQ_Y: begin
                w_cmd.sq_y = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_axis = 1'b0;
                if (i_stat.short_move) begin
                    w_cmd.unity = 1'b1;
                    n_state = S_MV_MUL;
                end else begin
                    w_cmd.sqrt_init = 1'b1;
                    n_count = '0;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                w_cmd.sqrt_step = 1'b1;
                n_count = r_count + CNT_W'(1);
                if (r_count == CNT_W'(SQRT_STEPS - 1)) begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (i_stat.norm_done) begin
                    n_state = S_LOG;
                end else begin
                    w_cmd.norm_step = 1'b1;
                end
            end
            S_LOG: begin
                w_cmd.log_step = 1'b1;
                n_state = S_POW;
            end
            S_POW: begin
                w_cmd.pow_step = 1'b1;
                n_state = S_EXP;
            end
            S_EXP: begin
                w_cmd.exp_step = 1'b1;
                n_state = S_SCALE;
            end
            S_SCALE: begin
                w_cmd.scale_step = 1'b1;
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                w_cmd.shift_step = 1'b1;
                n_axis  = 1'b0;
                n_state = S_MV_MUL;
            end
            S_MV_MUL: begin
                w_cmd.mv_mul = 1'b1;
                n_state = S_MV_FIN;
            end
            S_MV_FIN: begin
                w_cmd.mv_fin = 1'b1;
                if (!r_axis) begin
                    n_axis  = 1'b1;
                    n_state = S_MV_MUL;
                end else begin
                    n_out_kind = OUT_ROUND;
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= 1'b0;
            r_count     <= '0;
            r_have_prev <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_kind  <= OUT_ZERO;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_count     <= n_count;
            r_have_prev <= n_have_prev;
            r_out_valid <= n_out_valid;
            r_out_kind  <= n_out_kind;
        end
    end

    assign o_cmd       = w_cmd;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `PBM_ASSERT_IMPL(a_div_count, r_state == S_MAP_DIV, r_count < CNT_W'(DIV_STEPS))
    `PBM_ASSERT_NEXT(a_done_hands_off, w_cmd.out_load, r_out_valid && (r_state == S_IDLE))
    `PBM_ASSERT_NEXT(a_restart_clears, w_in_acc && i_mode, !r_have_prev && (r_state == S_DONE))
    `PBM_ASSERT_IMPL(a_move_needs_prev, r_state == S_SQ_X, r_have_prev)

endmodule

/* rtl/pointer_ballistics_mapper.sv */
// ----------------------------------------------------------------------------
// pointer_ballistics_mapper
// camera hand position to screen cursor with acceleration and edge snapping
// ----------------------------------------------------------------------------
// One request is worked at a time. A restart goes straight to the output,
// the first sample after restart runs the two 21-step window divisions, a
// small motion adds the distance and move steps, and a full move also runs
// a 22-step square root, a normalize loop and the log/exp gain. A new request
// is taken while the last result still waits on the output register.
module pointer_ballistics_mapper import pbm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_mode,
    input  logic [15:0]           i_cam_x,
    input  logic [15:0]           i_cam_y,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [12:0]           o_pixel_x,
    output logic [12:0]           o_pixel_y
);

    t_pbm_cmd  w_cmd;
    t_pbm_stat w_stat;

    pbm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_mode),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    pbm_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cam_x     (i_cam_x),
        .i_cam_y     (i_cam_y),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y)
    );

endmodule
